>>> src/alpha_blend_blit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the alpha blend blitter
// Concurrent checks clocked on clk and masked while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ALPHA_BLEND_BLIT_ASSERT_SVH
`define ALPHA_BLEND_BLIT_ASSERT_SVH

// same-cycle implication
`define ABB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ABB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/abb_pkg.sv
// ---------------------------------------------------------------------------
// abb_pkg
// Shared constants, register indexes and word types of the blitter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package abb_pkg;

    localparam int STORE_DEPTH = 262144;
    localparam int MEM_AW      = $clog2(STORE_DEPTH);

    localparam int CH_W        = 8;
    localparam int COLOR_W     = 32;
    localparam int OUT_AW      = 18;
    localparam int POS_W       = 12;
    localparam int SUM_W       = 13;
    localparam int PROD_W      = 26;
    localparam int FULL_AW     = 26;
    localparam int ALPHA_W     = 9;
    localparam int SHIFT_W     = 5;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_X      = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_START_Y      = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OPACITY      = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_SHIFT    = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_SHIFT  = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_BLUE_SHIFT   = 4'd7;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int ODEPTH  = 4;
    localparam int OPTR_W  = $clog2(ODEPTH);
    localparam int OCNT_W  = $clog2(ODEPTH + 1);

    // two front stages, mid queue, blend stage, result queue
    localparam int MAX_INFLIGHT = 2 + QDEPTH + 1 + ODEPTH;
    localparam int CHK_CNT_W    = $clog2(MAX_INFLIGHT + 1) + 1;

    typedef struct packed {
        logic [SUM_W-1:0]   screen_width;
        logic [POS_W-1:0]   start_x;
        logic [POS_W-1:0]   start_y;
        logic [SUM_W-1:0]   image_width;
        logic [ALPHA_W-1:0] opacity;
        logic [SHIFT_W-1:0] red_shift;
        logic [SHIFT_W-1:0] green_shift;
        logic [SHIFT_W-1:0] blue_shift;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        screen_width: 13'd640,
        start_x:      12'd0,
        start_y:      12'd0,
        image_width:  13'd1,
        opacity:      9'd256,
        red_shift:    5'd16,
        green_shift:  5'd8,
        blue_shift:   5'd0
    };

    typedef struct packed {
        logic [FULL_AW-1:0] addr;
        logic               in_store;
        logic [CH_W-1:0]    red;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    blue;
    } pix_item_t;

    typedef struct packed {
        logic [OUT_AW-1:0]  address;
        logic [COLOR_W-1:0] color;
        logic               out_of_range;
    } result_t;

endpackage

>>> src/abb_ram.sv
// ---------------------------------------------------------------------------
// abb_ram
// Generic one-write, one-read memory with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module abb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // a read at the address being written returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/abb_front.sv
// ---------------------------------------------------------------------------
// abb_front
// Takes pixels, tracks column and row, and forms the frame store address.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module abb_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  abb_pkg::cfg_t                cfg,
    input  logic                         hold,
    input  logic                         push,
    output logic                         full,
    input  logic [abb_pkg::CH_W-1:0]     red,
    input  logic [abb_pkg::CH_W-1:0]     green,
    input  logic [abb_pkg::CH_W-1:0]     blue,
    input  logic                         first_pixel,
    output logic                         q_push,
    output abb_pkg::pix_item_t           q_item,
    input  logic                         q_ready
);

    import abb_pkg::*;

    logic [POS_W-1:0]  column_reg, column_next;
    logic [POS_W-1:0]  row_reg, row_next;
    logic [POS_W-1:0]  col_eff, row_eff;
    logic [SUM_W-1:0]  col_inc;
    logic              wrap;
    logic [SUM_W-1:0]  y_pos;
    logic [SUM_W-1:0]  x_pos;
    logic [PROD_W-1:0] prod;

    logic              s1_valid_reg;
    logic [PROD_W-1:0] s1_prod_reg;
    logic [SUM_W-1:0]  s1_x_reg;
    logic [CH_W-1:0]   s1_red_reg, s1_green_reg, s1_blue_reg;

    logic              s2_valid_reg;
    pix_item_t         s2_item_reg;
    logic [FULL_AW-1:0] addr_sum;

    logic s2_free, s1_free, accept;

    assign s2_free = !s2_valid_reg || q_ready;
    assign s1_free = !s1_valid_reg || s2_free;
    assign full    = hold || !s1_free;
    assign accept  = push && !full;

    // a first pixel places itself at the image origin
    assign col_eff = first_pixel ? '0 : column_reg;
    assign row_eff = first_pixel ? '0 : row_reg;

    assign col_inc     = {1'b0, col_eff} + SUM_W'(1);
    assign wrap        = (col_inc >= cfg.image_width) || col_inc[SUM_W-1];
    assign column_next = wrap ? '0 : col_inc[POS_W-1:0];
    assign row_next    = wrap ? row_eff + POS_W'(1) : row_eff;

    assign y_pos = {1'b0, cfg.start_y} + {1'b0, row_eff};
    assign x_pos = {1'b0, cfg.start_x} + {1'b0, col_eff};
    assign prod  = PROD_W'(y_pos) * PROD_W'(cfg.screen_width);

    assign addr_sum = s1_prod_reg + FULL_AW'(s1_x_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg   <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                column_reg <= column_next;
                row_reg    <= row_next;
            end
            if (s1_free)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_prod_reg  <= prod;
            s1_x_reg     <= x_pos;
            s1_red_reg   <= red;
            s1_green_reg <= green;
            s1_blue_reg  <= blue;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_item_reg.addr     <= addr_sum;
            s2_item_reg.in_store <= addr_sum < FULL_AW'(STORE_DEPTH);
            s2_item_reg.red      <= s1_red_reg;
            s2_item_reg.green    <= s1_green_reg;
            s2_item_reg.blue     <= s1_blue_reg;
        end
    end

    assign q_push = s2_valid_reg && q_ready;
    assign q_item = s2_item_reg;

endmodule

>>> src/abb_queue.sv
// ---------------------------------------------------------------------------
// abb_queue
// Short queue of addressed pixels between the front and the blend side.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module abb_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  abb_pkg::pix_item_t push_item,
    output logic               ready,
    input  logic               pop,
    output abb_pkg::pix_item_t head,
    output logic               valid
);

    import abb_pkg::*;

    pix_item_t           slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign ready = count_reg != QCNT_W'(QDEPTH);
    assign valid = count_reg != '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> src/abb_back.sv
// ---------------------------------------------------------------------------
// abb_back
// Reads the background, blends, packs, writes back and queues the result.
// Also runs the frame store clearing pass after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module abb_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  abb_pkg::cfg_t          cfg,
    input  abb_pkg::pix_item_t     q_item,
    input  logic                   q_valid,
    output logic                   q_pop,
    output logic                   clearing,
    output abb_pkg::result_t       head,
    output logic                   empty,
    input  logic                   pop
);

    import abb_pkg::*;

    function automatic logic [CH_W-1:0] mix(
        input logic [CH_W-1:0]    src,
        input logic [CH_W-1:0]    bg,
        input logic [ALPHA_W-1:0] a,
        input logic [ALPHA_W-1:0] inv
    );
        logic [CH_W+ALPHA_W-1:0] acc;
        acc = (CH_W+ALPHA_W)'(src) * (CH_W+ALPHA_W)'(a)
            + (CH_W+ALPHA_W)'(bg) * (CH_W+ALPHA_W)'(inv);
        return acc[2*CH_W-1:CH_W];
    endfunction

    // clearing pass
    logic              clr_busy_reg;
    logic [MEM_AW-1:0] clr_addr_reg;

    // blend stage, valid for exactly one cycle per word
    logic              b1_valid_reg;
    pix_item_t         b1_item_reg;

    // last write, for a read that raced it
    logic               wr_valid_reg;
    logic [MEM_AW-1:0]  wr_addr_reg;
    logic [COLOR_W-1:0] wr_data_reg;

    // result queue
    result_t           out_reg [ODEPTH];
    logic [OPTR_W-1:0] out_wr_ptr_reg, out_rd_ptr_reg;
    logic [OCNT_W-1:0] out_cnt_reg;
    logic [OCNT_W:0]   room_need;
    logic              out_pop;

    logic               ram_we;
    logic [MEM_AW-1:0]  ram_waddr;
    logic [COLOR_W-1:0] ram_wdata;
    logic [COLOR_W-1:0] ram_rdata;
    logic [MEM_AW-1:0]  b1_idx;

    logic [ALPHA_W-1:0] alpha;
    logic [ALPHA_W-1:0] alpha_inv;
    logic               blending;
    logic [COLOR_W-1:0] bg;
    logic [CH_W-1:0]    ch_red, ch_green, ch_blue;
    logic [COLOR_W-1:0] color;
    result_t            res;

    assign clearing = clr_busy_reg;

    // take a word only when the result queue has room for it behind the blend stage
    assign room_need = {1'b0, out_cnt_reg} + (OCNT_W+1)'(b1_valid_reg);
    assign q_pop     = !clr_busy_reg && q_valid && (room_need < (OCNT_W+1)'(ODEPTH));

    assign b1_idx = b1_item_reg.addr[MEM_AW-1:0];

    assign alpha     = (cfg.opacity > ALPHA_ONE) ? ALPHA_ONE : cfg.opacity;
    assign alpha_inv = ALPHA_ONE - alpha;
    assign blending  = alpha != ALPHA_ONE;

    always_comb
    begin
        if (!b1_item_reg.in_store)
        begin
            bg = '0;
        end
        else if (wr_valid_reg && (wr_addr_reg == b1_idx))
        begin
            bg = wr_data_reg;
        end
        else
        begin
            bg = ram_rdata;
        end
    end

    assign ch_red   = blending ? mix(b1_item_reg.red, bg[23:16], alpha, alpha_inv)
                               : b1_item_reg.red;
    assign ch_green = blending ? mix(b1_item_reg.green, bg[15:8], alpha, alpha_inv)
                               : b1_item_reg.green;
    assign ch_blue  = blending ? mix(b1_item_reg.blue, bg[7:0], alpha, alpha_inv)
                               : b1_item_reg.blue;

    assign color = (COLOR_W'(ch_red) << cfg.red_shift)
                 | (COLOR_W'(ch_green) << cfg.green_shift)
                 | (COLOR_W'(ch_blue) << cfg.blue_shift);

    assign res.address      = b1_item_reg.addr[OUT_AW-1:0];
    assign res.color        = color;
    assign res.out_of_range = !b1_item_reg.in_store;

    always_comb
    begin
        if (clr_busy_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = b1_valid_reg && b1_item_reg.in_store;
            ram_waddr = b1_idx;
            ram_wdata = color;
        end
    end

    abb_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (q_pop),
        .raddr (q_item.addr[MEM_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign empty   = out_cnt_reg == '0;
    assign out_pop = pop && !empty;
    assign head    = out_reg[out_rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            b1_valid_reg   <= 1'b0;
            wr_valid_reg   <= 1'b0;
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_cnt_reg    <= '0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                if (clr_addr_reg == MEM_AW'(STORE_DEPTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + MEM_AW'(1);
            end
            b1_valid_reg <= q_pop;
            wr_valid_reg <= ram_we;
            if (b1_valid_reg)
            begin
                out_wr_ptr_reg <= out_wr_ptr_reg + OPTR_W'(1);
            end
            if (out_pop)
            begin
                out_rd_ptr_reg <= out_rd_ptr_reg + OPTR_W'(1);
            end
            if (b1_valid_reg && !out_pop)
            begin
                out_cnt_reg <= out_cnt_reg + OCNT_W'(1);
            end
            else if (out_pop && !b1_valid_reg)
            begin
                out_cnt_reg <= out_cnt_reg - OCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b1_item_reg <= q_item;
        end
        wr_addr_reg <= ram_waddr;
        wr_data_reg <= ram_wdata;
        if (b1_valid_reg)
        begin
            out_reg[out_wr_ptr_reg] <= res;
        end
    end

endmodule

>>> src/alpha_blend_blit.sv
// ---------------------------------------------------------------------------
// alpha_blend_blit
// An accepted pixel passes the front stages s1 and s2, the mid queue and the blend stage into the result queue.
// Throughput: one pixel per cycle while full is low; the store has one write and one read port.
// The front pipeline, mid queue and result side hold at most ten pixels.
// Reset: a clearing pass zeroes all 262144 words of the frame store, with full high.
// Configuration writes are taken at any time, ready is always high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module alpha_blend_blit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [abb_pkg::CH_W-1:0]            red,
    input  logic [abb_pkg::CH_W-1:0]            green,
    input  logic [abb_pkg::CH_W-1:0]            blue,
    input  logic                                first_pixel,
    output logic                                empty,
    input  logic                                pop,
    output logic [abb_pkg::OUT_AW-1:0]          write_address,
    output logic [abb_pkg::COLOR_W-1:0]         write_color,
    output logic                                out_of_range,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [abb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [abb_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import abb_pkg::*;

    cfg_t      cfg_reg;
    logic      clearing;
    logic      q_push, q_ready, q_pop, q_valid;
    pix_item_t q_in, q_head;
    result_t   res_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH: cfg_reg.screen_width <= cfg_data[SUM_W-1:0];
                REG_START_X:      cfg_reg.start_x      <= cfg_data[POS_W-1:0];
                REG_START_Y:      cfg_reg.start_y      <= cfg_data[POS_W-1:0];
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data[SUM_W-1:0];
                REG_OPACITY:      cfg_reg.opacity      <= cfg_data[ALPHA_W-1:0];
                REG_RED_SHIFT:    cfg_reg.red_shift    <= cfg_data[SHIFT_W-1:0];
                REG_GREEN_SHIFT:  cfg_reg.green_shift  <= cfg_data[SHIFT_W-1:0];
                REG_BLUE_SHIFT:   cfg_reg.blue_shift   <= cfg_data[SHIFT_W-1:0];
                default:          ;
            endcase
        end
    end

    abb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .hold        (clearing),
        .push        (push),
        .full        (full),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .first_pixel (first_pixel),
        .q_push      (q_push),
        .q_item      (q_in),
        .q_ready     (q_ready)
    );

    abb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .ready     (q_ready),
        .pop       (q_pop),
        .head      (q_head),
        .valid     (q_valid)
    );

    abb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_item   (q_head),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .clearing (clearing),
        .head     (res_head),
        .empty    (empty),
        .pop      (pop)
    );

    assign write_address = res_head.address;
    assign write_color   = res_head.color;
    assign out_of_range  = res_head.out_of_range;

endmodule

>>> src/abb_checker.sv
// ---------------------------------------------------------------------------
// abb_checker
// Port-level checks on pixel and result flow of the blitter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "alpha_blend_blit_assert.svh"

module abb_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  logic                            full,
    input  logic                            empty,
    input  logic                            pop,
    input  logic [abb_pkg::OUT_AW-1:0]      write_address,
    input  logic [abb_pkg::COLOR_W-1:0]     write_color,
    input  logic                            out_of_range
);

    import abb_pkg::*;

    logic [CHK_CNT_W-1:0] pend_reg;
    logic                 in_acc, out_acc;

    assign in_acc  = push && !full;
    assign out_acc = pop && !empty;

    // track words taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            pend_reg <= pend_reg + CHK_CNT_W'(1);
        end
        else if (out_acc && !in_acc)
        begin
            pend_reg <= pend_reg - CHK_CNT_W'(1);
        end
    end

    `ABB_ASSERT_IMPL(a_no_phantom_result, !empty, pend_reg != '0, "result with no pixel pending")

    `ABB_ASSERT_IMPL(a_pending_bound, 1'b1, pend_reg <= CHK_CNT_W'(MAX_INFLIGHT), "too many pixels in flight")

    `ABB_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(write_address) && $stable(write_color) && $stable(out_of_range), "stalled result changed")

endmodule

bind alpha_blend_blit abb_checker u_abb_checker (.*);
